### rtl/pol_pkg.sv
// Shared types and constants for the positional ordered list.
package pol_pkg;

  // Default sizing
  localparam int DEPTH_DEF      = 64;
  localparam int ELEM_WIDTH_DEF = 32;

  // Fixed port field widths
  localparam int KIND_W   = 3;
  localparam int POS_W    = 7;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 56;

  // Request kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 3'd0,
    KIND_DELETE = 3'd1,
    KIND_GET    = 3'd2,
    KIND_LOCATE = 3'd3,
    KIND_CLEAR  = 3'd4
  } kind_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_BAD_POS = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_EMPTY   = 2'd3
  } status_t;

  // Walk flavors over the element memory
  typedef enum logic [2:0] {
    MODE_NONE,
    MODE_UP,
    MODE_DOWN,
    MODE_READ,
    MODE_FIND
  } mode_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_PUT,
    ST_FIN
  } state_t;

endpackage

### rtl/pol_ram.sv
// Generic simple dual-port RAM with registered read.
module pol_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/positional_ordered_list.sv
// Insert, delete and locate walk the RAM one entry a cycle, and an insert that moves entries
// ends with a PUT state that writes the new value; get reads a single entry, while rejected
// requests and clear skip the RAM. Throughput: one word at a time, the RAM read port sets
// the walk rate; a new word is taken once the sequencer is idle, even while the previous
// result still waits on the output register.
// Reset: rst (synchronous) empties the list; RAM contents are not cleared.
module positional_ordered_list #(
  parameter int DEPTH      = pol_pkg::DEPTH_DEF,
  parameter int ELEM_WIDTH = pol_pkg::ELEM_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [6:0] position, [38:7] value, [39] zero
  input  logic [pol_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // [2:0] kind
  input  logic [pol_pkg::KIND_W-1:0]         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [1:0] status, [33:2] out_value, [40:34] found_position, [47:41] count,
  // [48] empty_flag, [55:49] zero
  output logic [pol_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = ((CW > pol_pkg::POS_W) ? CW : pol_pkg::POS_W) + 1;

  // Input fields
  logic [pol_pkg::POS_W-1:0] in_pos;
  logic [pol_pkg::VAL_W-1:0] in_val;
  logic                      in_fire;
  logic [XW-1:0]             pos_x;
  logic [XW-1:0]             cnt_x;

  assign in_pos  = s_axis_tdata[pol_pkg::POS_W-1:0];
  assign in_val  = s_axis_tdata[pol_pkg::POS_W +: pol_pkg::VAL_W];
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign pos_x   = XW'(in_pos);

  // Control state
  pol_pkg::state_t state, state_next;
  logic [CW-1:0]   count;
  logic [CW-1:0]   left;
  logic            rv;

  // Work registers
  pol_pkg::mode_t   mode;
  pol_pkg::status_t status;
  logic [AW-1:0]    addr;
  logic [AW-1:0]    raddr_q;
  logic [AW-1:0]    first_addr;
  logic [ELEM_WIDTH-1:0] val;
  logic [ELEM_WIDTH-1:0] outv;
  logic [CW-1:0]    found;
  logic             hit;
  logic [CW-1:0]    cnt_new;

  // Output register
  logic                      o_valid;
  logic [pol_pkg::STATUS_W-1:0] o_status;
  logic [pol_pkg::VAL_W-1:0] o_value;
  logic [pol_pkg::POS_W-1:0] o_found;
  logic [pol_pkg::POS_W-1:0] o_count;
  logic                      o_empty;

  // RAM ports
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [ELEM_WIDTH-1:0] ram_wdata;
  logic                  ram_re;
  logic [ELEM_WIDTH-1:0] ram_rdata;

  assign cnt_x = XW'(count);

  // Request decode at accept
  pol_pkg::mode_t   mode_dec;
  pol_pkg::status_t status_dec;
  logic [CW-1:0]    left_dec;
  logic [AW-1:0]    addr_dec;
  logic [CW-1:0]    cnt_dec;
  logic [XW-1:0]    span_x;

  always_comb begin
    span_x     = cnt_x - pos_x + XW'(1);
    mode_dec   = pol_pkg::MODE_NONE;
    status_dec = pol_pkg::STAT_OK;
    left_dec   = '0;
    addr_dec   = '0;
    cnt_dec    = count;
    case (s_axis_tuser)
      pol_pkg::KIND_INSERT: begin
        if (in_pos == '0 || pos_x > cnt_x + XW'(1)) begin
          status_dec = pol_pkg::STAT_BAD_POS;
        end else if (cnt_x >= XW'(DEPTH)) begin
          status_dec = pol_pkg::STAT_FULL;
        end else begin
          mode_dec = pol_pkg::MODE_UP;
          left_dec = CW'(span_x);
          addr_dec = AW'(cnt_x - XW'(1));
          cnt_dec  = count + CW'(1);
        end
      end
      pol_pkg::KIND_DELETE: begin
        if (count == '0) begin
          status_dec = pol_pkg::STAT_EMPTY;
        end else if (in_pos == '0 || pos_x > cnt_x) begin
          status_dec = pol_pkg::STAT_BAD_POS;
        end else begin
          mode_dec = pol_pkg::MODE_DOWN;
          left_dec = CW'(span_x);
          addr_dec = AW'(pos_x - XW'(1));
          cnt_dec  = count - CW'(1);
        end
      end
      pol_pkg::KIND_GET: begin
        if (in_pos == '0 || pos_x > cnt_x) begin
          status_dec = pol_pkg::STAT_BAD_POS;
        end else begin
          mode_dec = pol_pkg::MODE_READ;
          left_dec = CW'(1);
          addr_dec = AW'(pos_x - XW'(1));
        end
      end
      pol_pkg::KIND_LOCATE: begin
        mode_dec = pol_pkg::MODE_FIND;
        left_dec = count;
      end
      pol_pkg::KIND_CLEAR: begin
        cnt_dec = '0;
      end
      default: begin
        cnt_dec = count;
      end
    endcase
  end

  // Walk progress
  logic walk_done;
  logic out_free;
  logic match;

  assign walk_done = (left == '0) && !rv;
  assign out_free  = !o_valid || m_axis_tready;
  assign match     = rv && (mode == pol_pkg::MODE_FIND) && !hit && (ram_rdata == val);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      pol_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_next = (mode_dec == pol_pkg::MODE_NONE) ? pol_pkg::ST_FIN : pol_pkg::ST_WALK;
        end
      end
      pol_pkg::ST_WALK: begin
        if (walk_done) begin
          state_next = (mode == pol_pkg::MODE_UP) ? pol_pkg::ST_PUT : pol_pkg::ST_FIN;
        end
      end
      pol_pkg::ST_PUT: begin
        state_next = pol_pkg::ST_FIN;
      end
      pol_pkg::ST_FIN: begin
        if (out_free) begin
          state_next = pol_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pol_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs: handshake and RAM control
  always_comb begin
    s_axis_tready = 1'b0;
    ram_re        = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = raddr_q;
    ram_wdata     = ram_rdata;
    case (state)
      pol_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
      end
      pol_pkg::ST_WALK: begin
        ram_re = (left != '0);
        if (rv && mode == pol_pkg::MODE_UP) begin
          ram_we    = 1'b1;
          ram_waddr = raddr_q + AW'(1);
        end else if (rv && mode == pol_pkg::MODE_DOWN && raddr_q != first_addr) begin
          ram_we    = 1'b1;
          ram_waddr = raddr_q - AW'(1);
        end
      end
      pol_pkg::ST_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = first_addr;
        ram_wdata = val;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= pol_pkg::ST_IDLE;
      count   <= '0;
      left    <= '0;
      rv      <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == pol_pkg::ST_FIN && out_free) begin
        o_valid <= 1'b1;
      end else if (m_axis_tready) begin
        o_valid <= 1'b0;
      end
      case (state)
        pol_pkg::ST_IDLE: begin
          rv <= 1'b0;
          if (in_fire) begin
            left <= left_dec;
          end
        end
        pol_pkg::ST_WALK: begin
          rv <= ram_re;
          if (match) begin
            left <= '0;
          end else if (left != '0) begin
            left <= left - CW'(1);
          end
        end
        pol_pkg::ST_FIN: begin
          if (out_free) begin
            count <= cnt_new;
          end
        end
        default: begin
          rv <= 1'b0;
        end
      endcase
    end
  end

  // Work and result payload
  always_ff @(posedge clk) begin
    if (state == pol_pkg::ST_IDLE && in_fire) begin
      mode       <= mode_dec;
      status     <= status_dec;
      addr       <= addr_dec;
      first_addr <= (mode_dec == pol_pkg::MODE_UP) ? AW'(pos_x - XW'(1)) : addr_dec;
      val        <= ELEM_WIDTH'(signed'(in_val));
      outv       <= '0;
      found      <= '0;
      hit        <= 1'b0;
      cnt_new    <= cnt_dec;
    end
    if (state == pol_pkg::ST_WALK) begin
      raddr_q <= addr;
      if (ram_re) begin
        addr <= (mode == pol_pkg::MODE_UP) ? addr - AW'(1) : addr + AW'(1);
      end
      if (rv && mode == pol_pkg::MODE_READ) begin
        outv <= ram_rdata;
      end
      if (rv && mode == pol_pkg::MODE_DOWN && raddr_q == first_addr) begin
        outv <= ram_rdata;
      end
      if (match) begin
        hit   <= 1'b1;
        found <= CW'(raddr_q) + CW'(1);
      end
    end
    if (state == pol_pkg::ST_FIN && out_free) begin
      o_status <= status;
      o_value  <= pol_pkg::VAL_W'(signed'(outv));
      o_found  <= pol_pkg::POS_W'(found);
      o_count  <= pol_pkg::POS_W'(cnt_new);
      o_empty  <= (cnt_new == '0);
    end
  end

  // Element memory
  pol_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  // Result word
  assign m_axis_tvalid = o_valid;
  assign m_axis_tdata  = {7'b0, o_empty, o_count, o_found, o_value, o_status};

endmodule

### test/tb_top.sv
// Self-checking testbench for the positional ordered list over its request/result streams.
`timescale 1ns / 100ps

module tb_top;

  localparam int LIST_DEPTH     = pol_pkg::DEPTH_DEF;
  localparam int ITEM_TARGET    = 1825;  // directed words plus about 1800 random ones
  localparam int SETTLE_CYCLES  = LIST_DEPTH + 40;
  localparam int WATCHDOG_LIMIT = 2000;

  // Kinds with no defined request behind them
  localparam logic [pol_pkg::KIND_W-1:0] KIND_SPARE_LO = 3'd5;
  localparam logic [pol_pkg::KIND_W-1:0] KIND_SPARE_HI = 3'd7;
  localparam logic [pol_pkg::POS_W-1:0]  POS_MAX       = 7'd127;

  localparam logic [pol_pkg::VAL_W-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic [pol_pkg::VAL_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
  localparam logic [pol_pkg::VAL_W-1:0] VAL_NEG_ONE = 32'hFFFF_FFFF;

  // Receiver stall patterns
  localparam int SINK_STEADY = 0;
  localparam int SINK_COIN   = 1;
  localparam int SINK_BURSTY = 2;

  typedef struct packed {
    logic [pol_pkg::KIND_W-1:0] kind;
    logic [pol_pkg::POS_W-1:0]  position;
    logic [pol_pkg::VAL_W-1:0]  value;
  } list_req_t;

  typedef struct packed {
    pol_pkg::status_t           status;
    logic [pol_pkg::VAL_W-1:0]  out_value;
    logic [pol_pkg::POS_W-1:0]  found_position;
    logic [pol_pkg::POS_W-1:0]  count;
    logic                       empty_flag;
  } list_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // [6:0] position, [38:7] value, [39] zero
  logic [pol_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic [pol_pkg::KIND_W-1:0] s_axis_tuser = '0;      // [2:0] kind
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // [1:0] status, [33:2] out_value, [40:34] found_position, [47:41] count,
  // [48] empty_flag, [55:49] zero
  logic [pol_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

  list_req_t    pending_reqs[$];
  list_result_t expected_results[$];
  int           fail_count = 0;

  // Stimulus-side bookkeeping: list length and recent inserted values, to steer the sequences
  int                        gen_count = 0;
  logic [pol_pkg::VAL_W-1:0] value_pool[$];

  // Predicted list contents
  logic [pol_pkg::VAL_W-1:0] list_elems [LIST_DEPTH];
  int                        list_len = 0;

  logic word_taken = 1'b0;
  int   burst_left = 1;
  int   gap_left = 0;
  int   sink_mode = SINK_STEADY;
  int   sink_phase_left = 0;
  int   sink_hold = 0;
  int   quiet_cycles = 0;

  positional_ordered_list i_dut (
    clk,
    rst,
    s_axis_tvalid,
    s_axis_tready,
    s_axis_tdata,
    s_axis_tuser,
    m_axis_tvalid,
    m_axis_tready,
    m_axis_tdata
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Applies one request to the predicted list and returns its result
  function automatic list_result_t apply_request(list_req_t r);
    list_result_t res;
    int k;
    res = '{status: pol_pkg::STAT_OK, out_value: '0, found_position: '0, count: '0,
            empty_flag: 1'b0};
    case (r.kind)
      pol_pkg::KIND_INSERT: begin
        if (r.position == 0 || r.position > list_len + 1) begin
          res.status = pol_pkg::STAT_BAD_POS;
        end else if (list_len >= LIST_DEPTH) begin
          res.status = pol_pkg::STAT_FULL;
        end else begin
          for (k = list_len; k >= r.position; k--) list_elems[k] = list_elems[k-1];
          list_elems[r.position-1] = r.value;
          list_len++;
        end
      end
      pol_pkg::KIND_DELETE: begin
        if (list_len == 0) begin
          res.status = pol_pkg::STAT_EMPTY;
        end else if (r.position == 0 || r.position > list_len) begin
          res.status = pol_pkg::STAT_BAD_POS;
        end else begin
          res.out_value = list_elems[r.position-1];
          for (k = r.position; k < list_len; k++) list_elems[k-1] = list_elems[k];
          list_len--;
        end
      end
      pol_pkg::KIND_GET: begin
        if (r.position == 0 || r.position > list_len) res.status = pol_pkg::STAT_BAD_POS;
        else res.out_value = list_elems[r.position-1];
      end
      pol_pkg::KIND_LOCATE: begin
        for (k = list_len - 1; k >= 0; k--) begin
          if (list_elems[k] == r.value) res.found_position = pol_pkg::POS_W'(k + 1);
        end
      end
      pol_pkg::KIND_CLEAR: begin
        list_len = 0;
      end
      default: ;
    endcase
    res.count = pol_pkg::POS_W'(list_len);
    res.empty_flag = (list_len == 0);
    return res;
  endfunction

  // Queues a request and tracks the list length it leaves behind
  task automatic queue_req(logic [pol_pkg::KIND_W-1:0] kind, int position,
                           logic [pol_pkg::VAL_W-1:0] value);
    list_req_t r;
    r.kind = kind;
    r.position = pol_pkg::POS_W'(position);
    r.value = value;
    pending_reqs.push_back(r);
    if (kind == pol_pkg::KIND_INSERT && r.position >= 1 && r.position <= gen_count + 1 &&
        gen_count < LIST_DEPTH) begin
      gen_count++;
      value_pool.push_back(value);
      if (value_pool.size() > 32) void'(value_pool.pop_front());
    end else if (kind == pol_pkg::KIND_DELETE && gen_count > 0 && r.position >= 1 &&
                 r.position <= gen_count) begin
      gen_count--;
    end else if (kind == pol_pkg::KIND_CLEAR) begin
      gen_count = 0;
    end
  endtask

  function automatic logic [pol_pkg::VAL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return (value_pool.size() != 0) ?
                value_pool[$urandom_range(0, value_pool.size() - 1)] : VAL_NEG_ONE;
      3: return $urandom_range(0, 7);
      default: return $urandom;
    endcase
  endfunction

  // Mostly recently inserted values, so locate often finds something
  function automatic logic [pol_pkg::VAL_W-1:0] pick_probe();
    if (value_pool.size() != 0 && $urandom_range(0, 9) < 6)
      return value_pool[$urandom_range(0, value_pool.size() - 1)];
    return pick_value();
  endfunction

  task automatic build_stimulus();
    int roll;
    // Directed: empty-list checks, edge values, every kind, bad positions
    queue_req(pol_pkg::KIND_GET, 1, '0);
    queue_req(pol_pkg::KIND_DELETE, 0, '0);
    queue_req(pol_pkg::KIND_DELETE, 1, '0);
    queue_req(pol_pkg::KIND_INSERT, 0, 32'd9);
    queue_req(pol_pkg::KIND_INSERT, 2, 32'd9);
    queue_req(pol_pkg::KIND_INSERT, 1, VAL_MIN);
    queue_req(pol_pkg::KIND_INSERT, 2, VAL_MAX);
    queue_req(pol_pkg::KIND_INSERT, 1, '0);
    queue_req(pol_pkg::KIND_INSERT, 2, VAL_NEG_ONE);
    queue_req(pol_pkg::KIND_INSERT, POS_MAX, 32'd5);
    queue_req(pol_pkg::KIND_GET, 4, '0);
    queue_req(pol_pkg::KIND_GET, 0, '0);
    queue_req(pol_pkg::KIND_GET, 5, '0);
    queue_req(pol_pkg::KIND_LOCATE, 0, VAL_MAX);
    queue_req(pol_pkg::KIND_LOCATE, 0, 32'd12345);
    queue_req(pol_pkg::KIND_DELETE, 5, '0);
    queue_req(pol_pkg::KIND_DELETE, 0, '0);
    queue_req(pol_pkg::KIND_DELETE, 2, '0);
    queue_req(pol_pkg::KIND_DELETE, 3, '0);
    queue_req(KIND_SPARE_LO, 1, 32'd1);
    queue_req(KIND_SPARE_HI, 1, VAL_NEG_ONE);
    queue_req(pol_pkg::KIND_LOCATE, 0, VAL_MIN);
    queue_req(pol_pkg::KIND_CLEAR, 0, '0);
    queue_req(pol_pkg::KIND_GET, 1, '0);
    queue_req(pol_pkg::KIND_LOCATE, 0, '0);

    // Random: fill and drain runs, mixed traffic, clears and raw noise
    while (pending_reqs.size() < ITEM_TARGET) begin
      roll = $urandom_range(0, 9);
      if (roll <= 2) begin
        while (gen_count < LIST_DEPTH && pending_reqs.size() < ITEM_TARGET) begin
          case ($urandom_range(0, 9))
            0: queue_req(pol_pkg::KIND_GET, $urandom_range(0, gen_count + 1), pick_value());
            1: queue_req(pol_pkg::KIND_LOCATE, $urandom_range(0, POS_MAX), pick_probe());
            2: queue_req(pol_pkg::KIND_DELETE, $urandom_range(1, gen_count + 1),
                         pick_value());
            default: queue_req(pol_pkg::KIND_INSERT, $urandom_range(1, gen_count + 1),
                               pick_value());
          endcase
        end
        // Probe the full list
        repeat ($urandom_range(1, 4)) begin
          queue_req(pol_pkg::KIND_INSERT, $urandom_range(1, gen_count + 1), pick_value());
          queue_req(pol_pkg::KIND_INSERT, $urandom_range(gen_count + 2, POS_MAX),
                    pick_value());
          queue_req(pol_pkg::KIND_GET, $urandom_range(gen_count - 1, gen_count + 1), '0);
          queue_req(pol_pkg::KIND_LOCATE, 0, pick_probe());
        end
      end else if (roll <= 4) begin
        while (gen_count > 0 && pending_reqs.size() < ITEM_TARGET) begin
          case ($urandom_range(0, 9))
            0: queue_req(pol_pkg::KIND_GET, $urandom_range(1, gen_count), '0);
            1: queue_req(pol_pkg::KIND_LOCATE, 0, pick_probe());
            2: queue_req(pol_pkg::KIND_INSERT, $urandom_range(1, gen_count + 1),
                         pick_value());
            3: queue_req(pol_pkg::KIND_DELETE, $urandom_range(gen_count + 1, POS_MAX), '0);
            default: queue_req(pol_pkg::KIND_DELETE, $urandom_range(1, gen_count),
                               pick_value());
          endcase
        end
        queue_req(pol_pkg::KIND_DELETE, $urandom_range(0, POS_MAX), pick_value());
        queue_req(pol_pkg::KIND_GET, $urandom_range(0, 2), '0);
      end else if (roll <= 6) begin
        repeat (30) begin
          case ($urandom_range(0, 3))
            0: queue_req(pol_pkg::KIND_INSERT, $urandom_range(0, gen_count + 2),
                         pick_value());
            1: queue_req(pol_pkg::KIND_DELETE, $urandom_range(0, gen_count + 1),
                         pick_value());
            2: queue_req(pol_pkg::KIND_GET, $urandom_range(0, gen_count + 1), pick_value());
            default: queue_req(pol_pkg::KIND_LOCATE, $urandom_range(0, POS_MAX),
                               pick_probe());
          endcase
        end
      end else if (roll == 7) begin
        queue_req(pol_pkg::KIND_CLEAR, $urandom_range(0, POS_MAX), pick_value());
        queue_req(pol_pkg::KIND_LOCATE, 0, pick_probe());
      end else begin
        repeat (15) begin
          queue_req(pol_pkg::KIND_W'($urandom_range(0, KIND_SPARE_HI)),
                    $urandom_range(0, POS_MAX), $urandom);
        end
      end
    end
  endtask

  // Sender: bursts of words with random gaps between them
  always @(negedge clk) begin : driver
    list_req_t next_req;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (word_taken || !s_axis_tvalid) begin
      if (gap_left != 0) begin
        s_axis_tvalid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_reqs.size() != 0) begin
        next_req = pending_reqs.pop_front();
        s_axis_tuser <= next_req.kind;
        s_axis_tdata <= {1'b0, next_req.value, next_req.position};
        s_axis_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: switches between steady, coin-flip and bursty stall patterns
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (sink_phase_left == 0) begin
        sink_mode <= $urandom_range(SINK_STEADY, SINK_BURSTY);
        sink_phase_left <= $urandom_range(50, 300);
      end else begin
        sink_phase_left <= sink_phase_left - 1;
      end
      case (sink_mode)
        SINK_STEADY: m_axis_tready <= 1'b1;
        SINK_COIN: m_axis_tready <= 1'($urandom_range(0, 1));
        default: begin
          if (sink_hold != 0) begin
            sink_hold <= sink_hold - 1;
            m_axis_tready <= 1'b0;
          end else if ($urandom_range(0, 15) == 0) begin
            sink_hold <= $urandom_range(1, 20);
            m_axis_tready <= 1'b0;
          end else begin
            m_axis_tready <= 1'b1;
          end
        end
      endcase
    end
  end

  task automatic check_field(string name, logic [pol_pkg::VAL_W-1:0] want,
                             logic [pol_pkg::VAL_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  // Monitor: check results against the oldest prediction, then predict new words
  always @(posedge clk) begin : monitor
    list_req_t    req;
    list_result_t want;
    if (rst) begin
      word_taken <= 1'b0;
    end else begin
      word_taken <= s_axis_tvalid && s_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $error("result word with no request pending: 0x%0h", m_axis_tdata);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", pol_pkg::VAL_W'(want.status),
                      pol_pkg::VAL_W'(m_axis_tdata[1:0]));
          check_field("out_value", want.out_value, m_axis_tdata[33:2]);
          check_field("found_position", pol_pkg::VAL_W'(want.found_position),
                      pol_pkg::VAL_W'(m_axis_tdata[40:34]));
          check_field("count", pol_pkg::VAL_W'(want.count),
                      pol_pkg::VAL_W'(m_axis_tdata[47:41]));
          check_field("empty_flag", pol_pkg::VAL_W'(want.empty_flag),
                      pol_pkg::VAL_W'(m_axis_tdata[48]));
          check_field("pad", '0, pol_pkg::VAL_W'(m_axis_tdata[55:49]));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        req.kind = s_axis_tuser;
        req.position = s_axis_tdata[6:0];
        req.value = s_axis_tdata[38:7];
        expected_results.push_back(apply_request(req));
      end
    end
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Sequence: build stimulus, release reset, drain, report
  initial begin
    build_stimulus();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    while (pending_reqs.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      if (expected_results.size() != 0)
        $error("%0d results never arrived", expected_results.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
